@@ rtl/ring_queue_with_insert_assert.svh @@
// Assertion macros for the ring queue with positional insert.
`ifndef RING_QUEUE_WITH_INSERT_ASSERT_SVH
`define RING_QUEUE_WITH_INSERT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define RQI_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define RQI_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/rqi_pkg.sv @@
// Package with the types and codes of the ring queue with positional insert.
`default_nettype none

package rqi_pkg;

    localparam int DEPTH_DEF = 16;

    localparam logic [1:0] FUNC_PUSH   = 2'd0;
    localparam logic [1:0] FUNC_POP    = 2'd1;
    localparam logic [1:0] FUNC_INSERT = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    typedef logic [4:0] pos_t;
    typedef logic [4:0] occ_t;

    typedef struct packed {
        logic [1:0]  func;
        pos_t        pos;
        logic [31:0] req_id;
        logic [7:0]  req_type;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_id;
        logic [7:0]  out_type;
        occ_t        occupancy;
    } out_item_t;

    typedef struct packed {
        logic [31:0] req_id;
        logic [7:0]  req_type;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

@@ rtl/rqi_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module rqi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/ring_queue_with_insert.sv @@
// Top level of the ring queue with push, pop and insert at a logical position.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+----------------------------------
//   request | req_valid | req_stall | req (func, pos, req_id, req_type)
//   result  | rsp_valid | rsp_stall | rsp (status, out_id, out_type, occupancy)
//
// Push, append, front insert, overflow, empty pop and unused codes finish in S_EXEC.
// A pop that returns an entry also passes through S_POPRD for the registered RAM read.
// A middle insert does one RAM read and one write per moved entry in S_SHIFT, then S_INSWR.
// Reset clears head, tail and count; the entry RAM is not cleared.
// One result waits in the output register while the next item is taken;
// a second finished result holds the block until the first transfer.
`default_nettype none

module ring_queue_with_insert #(
    parameter int DEPTH = rqi_pkg::DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire rqi_pkg::in_item_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output rqi_pkg::out_item_t     rsp
);

    `include "ring_queue_with_insert_assert.svh"

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > $bits(rqi_pkg::pos_t)) ? CW : $bits(rqi_pkg::pos_t);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_POPRD = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_INSWR = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
        return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
    endfunction

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      rdaddr_reg, rdaddr_next;
    logic [CMPW-1:0]    cnt_reg, cnt_next;
    rqi_pkg::in_item_t  item_reg;
    rqi_pkg::out_item_t pend_reg;
    rqi_pkg::out_item_t rsp_reg;
    logic               rsp_valid_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    rqi_pkg::entry_t    ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    rqi_pkg::entry_t    ram_rdata;

    logic               req_xfer;
    logic               out_free;
    logic               fin;
    logic [1:0]         fin_status;
    rqi_pkg::entry_t    fin_entry;
    rqi_pkg::out_item_t fin_item;
    logic               full;
    logic [CMPW-1:0]    pos_ext;
    logic [CMPW-1:0]    count_ext;

    rqi_ram #(
        .WIDTH (rqi_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign pos_ext   = CMPW'(item_reg.pos);
    assign count_ext = CMPW'(count_reg);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        rdaddr_next = rdaddr_reg;
        cnt_next    = cnt_reg;
        ram_we      = 1'b0;
        ram_waddr   = tail_reg;
        ram_wdata   = '{req_id: item_reg.req_id, req_type: item_reg.req_type};
        ram_re      = 1'b0;
        ram_raddr   = head_reg;
        fin         = 1'b0;
        fin_status  = rqi_pkg::ST_OK;
        fin_entry   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (item_reg.func)
                    rqi_pkg::FUNC_PUSH, rqi_pkg::FUNC_INSERT:
                    begin
                        if (full)
                        begin
                            fin        = 1'b1;
                            fin_status = rqi_pkg::ST_OVERFLOW;
                        end
                        else if (item_reg.func == rqi_pkg::FUNC_PUSH)
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                            fin        = 1'b1;
                            if (count_reg == '0)
                            begin
                                ram_waddr = '0;
                                head_next = '0;
                                tail_next = wrap_inc('0);
                            end
                            else
                            begin
                                tail_next = wrap_inc(tail_reg);
                            end
                        end
                        else if (pos_ext >= count_ext)
                        begin
                            ram_we     = 1'b1;
                            tail_next  = wrap_inc(tail_reg);
                            count_next = count_reg + 1'b1;
                            fin        = 1'b1;
                        end
                        else if (item_reg.pos == '0)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = wrap_dec(head_reg);
                            head_next  = wrap_dec(head_reg);
                            count_next = count_reg + 1'b1;
                            fin        = 1'b1;
                        end
                        else
                        begin
                            ram_re      = 1'b1;
                            rdaddr_next = head_reg;
                            cnt_next    = CMPW'(1);
                            state_next  = S_SHIFT;
                        end
                    end
                    rqi_pkg::FUNC_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            fin        = 1'b1;
                            fin_status = rqi_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            state_next = S_POPRD;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_POPRD:
            begin
                fin        = 1'b1;
                fin_entry  = ram_rdata;
                head_next  = wrap_inc(head_reg);
                count_next = count_reg - 1'b1;
            end
            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = wrap_dec(rdaddr_reg);
                ram_wdata = ram_rdata;
                if (cnt_reg < pos_ext)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = wrap_inc(rdaddr_reg);
                    rdaddr_next = wrap_inc(rdaddr_reg);
                    cnt_next    = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_INSWR;
                end
            end
            S_INSWR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = rdaddr_reg;
                head_next  = wrap_dec(head_reg);
                count_next = count_reg + 1'b1;
                fin        = 1'b1;
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = out_free ? S_IDLE : S_WAIT;
        end

        fin_item = '{status:    fin_status,
                     out_id:    fin_entry.req_id,
                     out_type:  fin_entry.req_type,
                     occupancy: rqi_pkg::occ_t'(count_next)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if ((fin || state_reg == S_WAIT) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rdaddr_reg <= rdaddr_next;
        cnt_reg    <= cnt_next;
        if (req_xfer)
        begin
            item_reg <= req;
        end
        if (fin && !out_free)
        begin
            pend_reg <= fin_item;
        end
        if (fin && out_free)
        begin
            rsp_reg <= fin_item;
        end
        else if (state_reg == S_WAIT && out_free)
        begin
            rsp_reg <= pend_reg;
        end
    end

    `RQI_IMPLY(a_no_rw_same_entry, ram_we && ram_re, ram_waddr != ram_raddr,
        "entry RAM read and written at the same address")
    `RQI_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH),
        "queue count exceeds depth")
    `RQI_IMPLY(a_empty_pop_zero, rsp_valid && rsp.status == rqi_pkg::ST_EMPTY,
        rsp.out_id == '0 && rsp.out_type == '0 && rsp.occupancy == '0,
        "empty pop result carries a nonzero entry or count")

endmodule

`default_nettype wire
